// ----- src/tcw_pkg.sv -----
`timescale 1ns / 1ps
// shared constants, codes and types of the text console writer
package tcw_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    localparam int COL_W    = $clog2(COLUMNS);
    localparam int ROW_W    = $clog2(ROWS);
    localparam int ADDR_W   = $clog2(CELLS);
    localparam int SCAN_W   = $clog2(CELLS + 1);
    localparam int CELL_W   = 16;
    localparam int POS_W    = 12;
    localparam int CURSOR_W = 11;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STANDARD_COLOR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_COLOR    = 1'd1;

    localparam logic [7:0] STD_COLOR_RESET = 8'd15;
    localparam logic [7:0] ERR_COLOR_RESET = 8'd4;

    localparam logic [2:0] CMD_STREAM = 3'd0;
    localparam logic [2:0] CMD_PUT    = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_CLEAR  = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_E     = 8'h45;

    localparam int TAB_STEP = 4;

    typedef enum logic [3:0] {
        K_WRITE_ADV,
        K_WRITE_STAY,
        K_NEWLINE,
        K_RETURN,
        K_TAB,
        K_MARK_ERR,
        K_DELETE,
        K_CLEAR,
        K_READ,
        K_REPORT
    } tcw_kind_t;

    typedef struct packed {
        tcw_kind_t          kind;
        logic [7:0]         ch;
        logic [7:0]         attr;
        logic               use_cursor;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic               err;
        logic [POS_W-1:0]   pos;
        logic               pos_cur;
    } tcw_op_t;

endpackage

// ----- src/text_console_writer.sv -----
`timescale 1ns / 1ps
// top level of the text console writer
// Text-mode screen engine over an 80 x 25 grid of 16-bit cells (character in the low
// byte, attribute in the high byte) with a cursor. After reset the cell memory is
// swept to zero, one cell a cycle, so no item is taken until the sweep is done;
// configuration writes are taken at any time. A command queue of two items sits
// in front of the execution engine, and a finished result waits in an output
// register while new items are queued. An ordinary write, control code or report
// passes the engine in issue, execute and result steps, and a read adds a data
// step before the result, set by the single write and single registered read port
// of the cell memory. A clear sweeps every cell before its result; a write, newline
// or tab that runs past the last row scrolls the screen with a copy sweep through
// the same memory port.
module text_console_writer (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     cmd,
    input  logic [7:0]                     ch,
    input  logic signed [7:0]              col,
    input  logic signed [5:0]              row,
    input  logic [7:0]                     attr,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tcw_pkg::CURSOR_W-1:0]   cursor,
    output logic [tcw_pkg::POS_W-1:0]      position,
    output logic                           error,
    output logic [7:0]                     read_char,
    output logic [7:0]                     read_attr,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data
);

    import tcw_pkg::*;

    logic    push;
    tcw_op_t push_op;
    logic    pop;
    tcw_op_t head_op;
    logic    q_empty;
    logic    q_full;
    logic    fill_busy;

    tcw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .ch        (ch),
        .col       (col),
        .row       (row),
        .attr      (attr),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .fill_busy (fill_busy),
        .push      (push),
        .push_op   (push_op)
    );

    tcw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .empty   (q_empty),
        .full    (q_full)
    );

    tcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .head_op   (head_op),
        .pop       (pop),
        .fill_busy (fill_busy),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cursor    (cursor),
        .position  (position),
        .error     (error),
        .read_char (read_char),
        .read_attr (read_attr)
    );

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_empty)
        else $error("item taken from an empty queue");

    a_no_item_during_init: assert property (@(posedge clk) disable iff (!rst_n)
        fill_busy |-> !push && q_empty)
        else $error("item accepted before the cell memory was cleared");

    a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && error |-> read_char == 8'd0 && read_attr == 8'd0)
        else $error("error result carries cell data");

    a_position_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !error |-> {1'b0, position} < 13'(CELLS))
        else $error("position outside the grid without error");

endmodule

// ----- src/tcw_ram.sv -----
`timescale 1ns / 1ps
// generic single write port ram with registered read
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/tcw_front.sv -----
`timescale 1ns / 1ps
// front end: configuration registers, input handshake and command decode
module tcw_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     cmd,
    input  logic [7:0]                     ch,
    input  logic signed [7:0]              col,
    input  logic signed [5:0]              row,
    input  logic [7:0]                     attr,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           q_full,
    input  logic                           fill_busy,
    output logic                           push,
    output tcw_pkg::tcw_op_t               push_op
);

    import tcw_pkg::*;

    logic [7:0]       std_color_reg;
    logic [7:0]       err_color_reg;
    logic             col_oob;
    logic             row_oob;
    logic             oob;
    logic             use_cur;
    logic [POS_W-1:0] row_sx;
    logic [POS_W-1:0] col_sx;
    logic [POS_W-1:0] pos_err;
    logic [7:0]       put_attr;
    tcw_op_t          op;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_color_reg <= STD_COLOR_RESET;
            err_color_reg <= ERR_COLOR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_STANDARD_COLOR: std_color_reg <= cfg_data;
                CFG_ERROR_COLOR:    err_color_reg <= cfg_data;
            endcase
        end
    end

    assign col_oob  = !col[7] && (9'(col[6:0]) >= 9'(COLUMNS));
    assign row_oob  = !row[5] && (7'(row[4:0]) >= 7'(ROWS));
    assign oob      = col_oob || row_oob;
    assign use_cur  = col[7] || row[5];
    assign row_sx   = {{(POS_W-6){row[5]}}, row};
    assign col_sx   = {{(POS_W-8){col[7]}}, col};
    assign pos_err  = POS_W'(row_sx * POS_W'(COLUMNS)) + col_sx;
    assign put_attr = (attr == 8'd0) ? std_color_reg : attr;

    always_comb
    begin
        op            = '0;
        op.kind       = K_REPORT;
        op.ch         = ch;
        op.attr       = std_color_reg;
        op.use_cursor = 1'b1;
        unique case (cmd)
            CMD_STREAM:
            begin
                priority if (ch == CH_NL)
                    op.kind = K_NEWLINE;
                else if (ch == CH_CR)
                    op.kind = K_RETURN;
                else if (ch == CH_TAB)
                    op.kind = K_TAB;
                else
                    op.kind = K_WRITE_ADV;
            end
            CMD_PUT:
            begin
                if (oob)
                begin
                    op.kind       = K_MARK_ERR;
                    op.ch         = CH_E;
                    op.attr       = err_color_reg;
                    op.use_cursor = 1'b0;
                    op.row        = ROW_W'(ROWS - 1);
                    op.col        = COL_W'(COLUMNS - 1);
                    op.err        = 1'b1;
                    op.pos        = pos_err;
                end
                else
                begin
                    op.use_cursor = use_cur;
                    op.row        = ROW_W'(row[4:0]);
                    op.col        = COL_W'(col[6:0]);
                    op.attr       = put_attr;
                    op.pos_cur    = 1'b1;
                    priority if (ch == CH_NL)
                        op.kind = K_NEWLINE;
                    else if (ch == CH_BS)
                    begin
                        op.kind = K_WRITE_STAY;
                        op.ch   = CH_SPACE;
                    end
                    else
                        op.kind = K_WRITE_ADV;
                end
            end
            CMD_DELETE:
            begin
                op.kind = K_DELETE;
                op.ch   = CH_SPACE;
            end
            CMD_CLEAR:
            begin
                op.kind = K_CLEAR;
                op.ch   = CH_SPACE;
            end
            CMD_READ:
            begin
                if (oob)
                begin
                    op.err = 1'b1;
                    op.pos = pos_err;
                end
                else
                begin
                    op.kind       = K_READ;
                    op.use_cursor = use_cur;
                    op.row        = ROW_W'(row[4:0]);
                    op.col        = COL_W'(col[6:0]);
                end
            end
            default:
            begin
                op.kind = K_REPORT;
            end
        endcase
    end

    assign in_stall = q_full || fill_busy;
    assign push     = in_valid && !in_stall;
    assign push_op  = op;

endmodule

// ----- src/tcw_queue.sv -----
`timescale 1ns / 1ps
// short command queue between front end and back end
module tcw_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tcw_pkg::tcw_op_t push_op,
    input  logic             pop,
    output tcw_pkg::tcw_op_t head_op,
    output logic             empty,
    output logic             full
);

    import tcw_pkg::*;

    tcw_op_t           slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_op = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ----- src/tcw_back.sv -----
`timescale 1ns / 1ps
// back end: cursor, cell memory, scroll and fill sweeps, result register
module tcw_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            q_empty,
    input  tcw_pkg::tcw_op_t                head_op,
    output logic                            pop,
    output logic                            fill_busy,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [tcw_pkg::CURSOR_W-1:0]    cursor,
    output logic [tcw_pkg::POS_W-1:0]       position,
    output logic                            error,
    output logic [7:0]                      read_char,
    output logic [7:0]                      read_attr
);

    import tcw_pkg::*;

    localparam logic [2:0] ST_FILL   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_RDATA  = 3'd3;
    localparam logic [2:0] ST_SCROLL = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    localparam logic [COL_W:0] COLS_X = (COL_W + 1)'(COLUMNS);

    logic [2:0]          state_reg, state_next;
    logic [SCAN_W-1:0]   scan_reg, scan_next;
    logic                init_reg, init_next;
    logic [CELL_W-1:0]   fill_data_reg, fill_data_next;
    logic [ROW_W-1:0]    cur_row_reg, cur_row_next;
    logic [COL_W-1:0]    cur_col_reg, cur_col_next;
    tcw_op_t             op_reg, op_next;
    logic                res_err_reg, res_err_next;
    logic [POS_W-1:0]    res_pos_reg, res_pos_next;
    logic                res_pos_cur_reg, res_pos_cur_next;
    logic [7:0]          res_char_reg, res_char_next;
    logic [7:0]          res_attr_reg, res_attr_next;
    logic                out_valid_reg, out_valid_next;
    logic [CURSOR_W-1:0] cursor_reg;
    logic [POS_W-1:0]    position_reg;
    logic                error_reg;
    logic [7:0]          read_char_reg;
    logic [7:0]          read_attr_reg;

    logic                out_load;
    logic [ROW_W-1:0]    t_row;
    logic [COL_W-1:0]    t_col;
    logic [ADDR_W-1:0]   t_addr;
    logic                last_row;
    logic [COL_W:0]      col_inc;
    logic [COL_W:0]      col_tab;
    logic                mv_update;
    logic                mv_step;
    logic                mv_we;
    logic [COL_W-1:0]    mv_col;
    logic [POS_W-1:0]    cursor_idx;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [CELL_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [CELL_W-1:0]   ram_rdata;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // target cell of the current item
    always_comb
    begin
        if (op_reg.kind == K_DELETE)
        begin
            priority if (cur_row_reg == '0 && cur_col_reg == '0)
            begin
                t_row = '0;
                t_col = '0;
            end
            else if (cur_col_reg == '0)
            begin
                t_row = cur_row_reg - 1'b1;
                t_col = COL_W'(COLUMNS - 1);
            end
            else
            begin
                t_row = cur_row_reg;
                t_col = cur_col_reg - 1'b1;
            end
        end
        else if (op_reg.use_cursor)
        begin
            t_row = cur_row_reg;
            t_col = cur_col_reg;
        end
        else
        begin
            t_row = op_reg.row;
            t_col = op_reg.col;
        end
    end

    assign t_addr   = ADDR_W'(ADDR_W'(t_row) * ADDR_W'(COLUMNS)) + ADDR_W'(t_col);
    assign last_row = (t_row == ROW_W'(ROWS - 1));
    assign col_inc  = {1'b0, t_col} + 1'b1;
    assign col_tab  = {1'b0, t_col} + (COL_W + 1)'(TAB_STEP);

    // cursor movement per item kind
    always_comb
    begin
        mv_update = 1'b1;
        mv_step   = 1'b0;
        mv_we     = 1'b0;
        mv_col    = t_col;
        unique case (op_reg.kind)
            K_WRITE_ADV:
            begin
                mv_we = 1'b1;
                if (col_inc == COLS_X)
                begin
                    mv_step = 1'b1;
                    mv_col  = '0;
                end
                else
                begin
                    mv_col = COL_W'(col_inc);
                end
            end
            K_WRITE_STAY, K_DELETE:
            begin
                mv_we = 1'b1;
            end
            K_NEWLINE:
            begin
                mv_step = 1'b1;
                mv_col  = '0;
            end
            K_RETURN:
            begin
                mv_col = '0;
            end
            K_TAB:
            begin
                if (col_tab >= COLS_X)
                begin
                    mv_step = 1'b1;
                    mv_col  = COL_W'(col_tab - COLS_X);
                end
                else
                begin
                    mv_col = COL_W'(col_tab);
                end
            end
            K_MARK_ERR:
            begin
                mv_we     = 1'b1;
                mv_update = 1'b0;
            end
            K_CLEAR, K_READ, K_REPORT:
            begin
                mv_update = 1'b0;
            end
            default:
            begin
                mv_update = 1'b0;
            end
        endcase
    end

    assign cursor_idx = POS_W'(POS_W'(cur_row_reg) * POS_W'(COLUMNS)) + POS_W'(cur_col_reg);

    always_comb
    begin
        state_next       = state_reg;
        scan_next        = scan_reg;
        init_next        = init_reg;
        fill_data_next   = fill_data_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        op_next          = op_reg;
        res_err_next     = res_err_reg;
        res_pos_next     = res_pos_reg;
        res_pos_cur_next = res_pos_cur_reg;
        res_char_next    = res_char_reg;
        res_attr_next    = res_attr_reg;
        pop              = 1'b0;
        out_load         = 1'b0;
        ram_we           = 1'b0;
        ram_waddr        = t_addr;
        ram_wdata        = {op_reg.attr, op_reg.ch};
        ram_raddr        = t_addr;
        unique case (state_reg)
            ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(scan_reg);
                ram_wdata = fill_data_reg;
                if (scan_reg == SCAN_W'(CELLS - 1))
                begin
                    scan_next  = '0;
                    init_next  = 1'b0;
                    state_next = init_reg ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    op_next    = head_op;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                res_err_next     = op_reg.err;
                res_pos_next     = (op_reg.kind == K_READ) ? POS_W'(t_addr) : op_reg.pos;
                res_pos_cur_next = op_reg.pos_cur;
                res_char_next    = '0;
                res_attr_next    = '0;
                ram_we           = mv_we;
                state_next       = ST_DONE;
                if (mv_update)
                begin
                    if (mv_step && last_row)
                    begin
                        cur_row_next = ROW_W'(ROWS - 1);
                        cur_col_next = '0;
                        scan_next    = '0;
                        state_next   = ST_SCROLL;
                    end
                    else
                    begin
                        cur_row_next = mv_step ? t_row + 1'b1 : t_row;
                        cur_col_next = mv_col;
                    end
                end
                if (op_reg.kind == K_CLEAR)
                begin
                    cur_row_next   = '0;
                    cur_col_next   = '0;
                    scan_next      = '0;
                    fill_data_next = {op_reg.attr, op_reg.ch};
                    state_next     = ST_FILL;
                end
                else if (op_reg.kind == K_READ)
                begin
                    state_next = ST_RDATA;
                end
            end
            ST_RDATA:
            begin
                res_char_next = ram_rdata[7:0];
                res_attr_next = ram_rdata[15:8];
                state_next    = ST_DONE;
            end
            ST_SCROLL:
            begin
                // read one row ahead, write the cell a row above in the next cycle
                if (scan_reg < SCAN_W'(CELLS - COLUMNS))
                begin
                    ram_raddr = ADDR_W'(scan_reg + SCAN_W'(COLUMNS));
                end
                if (scan_reg != '0)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = ADDR_W'(scan_reg - 1'b1);
                    ram_wdata = (scan_reg <= SCAN_W'(CELLS - COLUMNS)) ? ram_rdata : '0;
                end
                if (scan_reg == SCAN_W'(CELLS))
                begin
                    scan_next  = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            scan_reg      <= '0;
            init_reg      <= 1'b1;
            fill_data_reg <= '0;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_reg      <= scan_next;
            init_reg      <= init_next;
            fill_data_reg <= fill_data_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        res_err_reg     <= res_err_next;
        res_pos_reg     <= res_pos_next;
        res_pos_cur_reg <= res_pos_cur_next;
        res_char_reg    <= res_char_next;
        res_attr_reg    <= res_attr_next;
        if (out_load)
        begin
            cursor_reg    <= CURSOR_W'(cursor_idx);
            position_reg  <= res_pos_cur_reg ? cursor_idx : res_pos_reg;
            error_reg     <= res_err_reg;
            read_char_reg <= res_char_reg;
            read_attr_reg <= res_attr_reg;
        end
    end

    assign fill_busy = init_reg;
    assign out_valid = out_valid_reg;
    assign cursor    = cursor_reg;
    assign position  = position_reg;
    assign error     = error_reg;
    assign read_char = read_char_reg;
    assign read_attr = read_attr_reg;

endmodule
